/* hdl/hpq_pkg.sv */
// Package for the binary heap priority queue: request and status codes,
// field widths, controller states and the ordering compare. No dependencies.
`default_nettype none

package hpq_pkg;

    localparam int VALUE_W = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Heap order register values
    localparam logic ORDER_MAX = 1'b0;
    localparam logic ORDER_MIN = 1'b1;

    localparam t_value EMPTY_VALUE = -32'sd1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UP,
        S_DN_LAST,
        S_DN
    } t_state;

    // True if a must sit above b under the given order (strict)
    function automatic logic ranks_before(input t_value a, input t_value b,
                                          input logic order);
        if (order == ORDER_MIN) begin
            return a < b;
        end else begin
            return a > b;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/hpq_if.sv */
// Valid/ready channel interfaces of the heap queue: request, response and
// configuration write. Depends on hpq_pkg for widths.
`default_nettype none

interface hpq_req_if import hpq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface hpq_rsp_if import hpq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   top_value;
    logic [STAT_W-1:0]    status;
    logic [COUNT_W-1:0]   count;

    modport source (output valid, output top_value, output status, output count,
                    input ready);
    modport sink   (input valid, input top_value, input status, input count,
                    output ready);
endinterface

interface hpq_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/binary_heap_priority_queue.sv */
// Binary heap priority queue top level: heap memory, sift controller and
// response register. Depends on hpq_pkg and the interfaces in hpq_if.sv.
//
// Holds up to CAPACITY signed 32-bit values in a binary heap kept in one
// memory with two registered read ports and one write port. Every request
// (insert, extract, peek) gives exactly one response, which is formed when
// the request is taken and waits in an output register. Peek, an insert into
// an empty heap, an extract of the only element, and any refused request
// (insert when full, extract or peek when empty) need no sift. Other inserts
// sift the value up; other extracts read the last element and sift it down
// from the root, at most log2(CAPACITY) levels: each level is one memory read,
// compare and write-back. The root is also kept in a register, so peeks and
// the returned top need no memory read. The user must change the heap_order
// register (0 = max first, 1 = min first) only while idle; not enforced by
// the block. Stored values are not reordered. No clearing pass after reset.
`default_nettype none

module binary_heap_priority_queue
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hpq_req_if.sink      i_req,
    hpq_rsp_if.source    o_rsp,
    hpq_cfg_if.sink      i_cfg
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    // Heap storage
    t_value  mem [CAPACITY];
    t_value  r_rd_a;
    t_value  r_rd_b;

    // Control and datapath registers
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_order;
    logic [AW-1:0]    r_pos, n_pos;
    t_value           r_val, n_val;
    t_value           r_root;

    // Response register
    logic             r_rsp_valid;
    t_value           r_rsp_top;
    t_status          r_rsp_status;
    logic [COUNT_W-1:0] r_rsp_count;

    // Memory port controls
    logic             w_we;
    logic [AW-1:0]    w_wa;
    t_value           w_wd;
    logic [AW-1:0]    w_ra;
    logic [AW-1:0]    w_rb;

    // Handshake and response fields
    logic             w_acc;
    logic             w_rsp_load;
    t_value           w_top;
    t_status          w_status;

    // Sift decisions
    logic             w_up_go;
    logic [LW-1:0]    w_left;
    logic [LW-1:0]    w_right;
    logic             w_have_l;
    logic             w_have_r;
    logic             w_pick_r;
    t_value           w_pick_val;
    logic [AW-1:0]    w_pick_idx;
    logic             w_dn_go;
    logic [CW-1:0]    w_cnt_dec;

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        return (p - AW'(1)) >> 1;
    endfunction

    function automatic logic [AW-1:0] left_of(input logic [AW-1:0] p);
        return AW'((LW'(p) << 1) + LW'(1));
    endfunction

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.top_value = r_rsp_top;
    assign o_rsp.status    = r_rsp_status;
    assign o_rsp.count     = r_rsp_count;

    assign w_cnt_dec = r_count - CW'(1);

    // Sift-up: move on while the held value ranks before its parent
    assign w_up_go = (r_pos != '0) && ranks_before(r_val, r_rd_a, r_order);

    // Sift-down: pick the child that ranks first, right on a tie
    assign w_left     = (LW'(r_pos) << 1) + LW'(1);
    assign w_right    = w_left + LW'(1);
    assign w_have_l   = w_left < LW'(r_count);
    assign w_have_r   = w_right < LW'(r_count);
    assign w_pick_r   = w_have_r && !ranks_before(r_rd_a, r_rd_b, r_order);
    assign w_pick_val = w_pick_r ? r_rd_b : r_rd_a;
    assign w_pick_idx = w_pick_r ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_dn_go    = w_have_l && ranks_before(w_pick_val, r_val, r_order);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_count != CW'(CAPACITY) && r_count != '0) begin
                                n_state = S_UP;
                            end
                        end
                        REQ_EXTRACT: begin
                            if (r_count > CW'(1)) begin
                                n_state = S_DN_LAST;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_UP:      n_state = w_up_go ? S_UP : S_IDLE;
            S_DN_LAST: n_state = S_DN;
            S_DN:      n_state = w_dn_go ? S_DN : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        w_we       = 1'b0;
        w_wa       = r_pos;
        w_wd       = r_val;
        w_ra       = '0;
        w_rb       = '0;
        n_pos      = r_pos;
        n_val      = r_val;
        n_count    = r_count;
        w_rsp_load = 1'b0;
        w_top      = '0;
        w_status   = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_rsp_load = 1'b1;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                w_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_pos   = r_count[AW-1:0];
                                n_val   = i_req.value;
                                if (r_count == '0) begin
                                    w_we = 1'b1;
                                    w_wa = '0;
                                    w_wd = i_req.value;
                                end else begin
                                    w_ra = parent_of(r_count[AW-1:0]);
                                end
                            end
                        end
                        REQ_EXTRACT: begin
                            if (r_count == '0) begin
                                w_top    = EMPTY_VALUE;
                                w_status = ST_EMPTY;
                            end else begin
                                w_top   = r_root;
                                n_count = w_cnt_dec;
                                // fetch the last element to refill the root
                                w_ra    = w_cnt_dec[AW-1:0];
                            end
                        end
                        REQ_PEEK: begin
                            if (r_count == '0) begin
                                w_top    = EMPTY_VALUE;
                                w_status = ST_EMPTY;
                            end else begin
                                w_top = r_root;
                            end
                        end
                        default: w_top = '0;
                    endcase
                end
            end
            S_UP: begin
                w_we = 1'b1;
                if (w_up_go) begin
                    // parent moves down into the hole
                    w_wd  = r_rd_a;
                    n_pos = parent_of(r_pos);
                    w_ra  = parent_of(parent_of(r_pos));
                end
            end
            S_DN_LAST: begin
                n_val = r_rd_a;
                n_pos = '0;
                w_ra  = AW'(1);
                w_rb  = AW'(2);
            end
            S_DN: begin
                w_we = 1'b1;
                if (w_dn_go) begin
                    // chosen child moves up into the hole
                    w_wd  = w_pick_val;
                    n_pos = w_pick_idx;
                    w_ra  = left_of(w_pick_idx);
                    w_rb  = left_of(w_pick_idx) + AW'(1);
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    // Heap memory, registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_a <= mem[w_ra];
        r_rd_b <= mem[w_rb];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_order     <= ORDER_MAX;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_order <= i_cfg.data;
            end
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_val <= n_val;
        // root copy follows every write to the root entry
        if (w_we && w_wa == '0) begin
            r_root <= w_wd;
        end
        if (w_rsp_load) begin
            r_rsp_top    <= w_top;
            r_rsp_status <= w_status;
            r_rsp_count  <= COUNT_W'(n_count);
        end
    end

    // Assertions
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE))
        else $error("request taken while a sift is running");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.req_type == REQ_INSERT && r_count != CW'(CAPACITY))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one element");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_count == $past(r_count)))
        else $error("element count changed during a sift");

endmodule

`default_nettype wire
